FILE: rtl/core/hbss_pkg.sv
// Package for the hash bucket slot store: operation codes, controller
// states and the structs passed between the controller and the slot cells.
// No dependencies.
package hbss_pkg;

  localparam int unsigned DefaultSlots = 32;
  localparam int unsigned KeyW         = 32;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned KindW        = 2;
  localparam int unsigned CountOutW    = 6;

  // Operation codes; the fourth code is unused and handled by a default arm
  typedef enum logic [KindW-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT
  } state_e;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [ValueW-1:0] value;
    logic              ins_go;    // write the pair into the lowest free slot
    logic              rem_go;    // drop the lowest slot holding the pair
    logic              set_pend;  // capture key hits as pending lookup results
    logic              pop;       // retire the lowest pending result
  } cell_ctrl_t;

  // Priority chain handed from one cell to the next
  typedef struct packed {
    logic free;  // some lower slot is free
    logic pair;  // some lower slot holds the exact pair
    logic pend;  // some lower slot has a pending lookup result
  } cell_chain_t;

  // Per-cell status seen by the controller
  typedef struct packed {
    logic key_hit;  // valid slot with matching key
    logic pend;     // pending lookup result
    logic sel;      // lowest pending result
  } cell_status_t;

endpackage

FILE: rtl/core/hbss_cell.sv
// One slot of the bucket: key, value, valid bit and lookup pending bit.
// Depends on hbss_pkg; instanced in a row by hash_bucket_slot_store.
module hbss_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  hbss_pkg::cell_ctrl_t       ctrl_i,
  input  hbss_pkg::cell_chain_t      chain_i,
  output hbss_pkg::cell_chain_t      chain_o,
  output hbss_pkg::cell_status_t     status_o,
  output logic [hbss_pkg::ValueW-1:0] value_o
);
  import hbss_pkg::*;

  logic [KeyW-1:0]   key_q;
  logic [ValueW-1:0] value_q;
  logic              valid_q, valid_d;
  logic              pend_q, pend_d;
  logic              key_hit, pair_hit;
  logic              first_free, first_pair, sel;

  // Compare against the broadcast item
  assign key_hit  = valid_q && (key_q == ctrl_i.key);
  assign pair_hit = key_hit && (value_q == ctrl_i.value);

  // Resolve priority with the lower neighbors
  assign first_free   = !valid_q && !chain_i.free;
  assign first_pair   = pair_hit && !chain_i.pair;
  assign sel          = pend_q && !chain_i.pend;
  assign chain_o.free = chain_i.free || !valid_q;
  assign chain_o.pair = chain_i.pair || pair_hit;
  assign chain_o.pend = chain_i.pend || pend_q;

  assign status_o.key_hit = key_hit;
  assign status_o.pend    = pend_q;
  assign status_o.sel     = sel;
  assign value_o          = sel ? value_q : '0;

  // Set on insert, clear on remove
  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.ins_go && first_free) begin
      valid_d = 1'b1;
    end else if (ctrl_i.rem_go && first_pair) begin
      valid_d = 1'b0;
    end
  end

  // Capture hits for a lookup, retire once emitted
  always_comb begin
    pend_d = pend_q;
    if (ctrl_i.set_pend) begin
      pend_d = key_hit;
    end else if (ctrl_i.pop && sel) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  // Store the pair on insert
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins_go && first_free) begin
      key_q   <= ctrl_i.key;
      value_q <= ctrl_i.value;
    end
  end

endmodule

FILE: rtl/core/hash_bucket_slot_store.sv
// Hash bucket slot store top level: controller, result register and a row
// of hbss_cell slots. Depends on hbss_pkg and hbss_cell.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_ready_o | kind_i, key_i, value_i
//  out     | output    | out_valid_o/out_ready_i | ok_o, matched_value_o, last_o,
//          |           |                      | full_res_o, empty_res_o, valid_count_o
//
// Every transaction is accepted in ST_IDLE; in ST_EVAL every cell compares
// in parallel and the priority chain picks a slot. A lookup with matches
// then goes to ST_EMIT, which retires the matches one by one, lowest first,
// from the cell row into the result register. Reset clears all valid
// bits at once. A stalled result register holds the controller; a new
// transaction is taken while the last result still waits to be taken.
module hash_bucket_slot_store #(
  parameter int unsigned SLOTS = hbss_pkg::DefaultSlots
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hbss_pkg::KindW-1:0]    kind_i,
  input  logic [hbss_pkg::KeyW-1:0]     key_i,
  input  logic [hbss_pkg::ValueW-1:0]   value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          ok_o,
  output logic [hbss_pkg::ValueW-1:0]   matched_value_o,
  output logic                          last_o,
  output logic                          full_res_o,
  output logic                          empty_res_o,
  output logic [hbss_pkg::CountOutW-1:0] valid_count_o
);
  import hbss_pkg::*;

  localparam int unsigned CntW = $clog2(SLOTS + 1);

  state_e              state_q, state_d;
  logic [KindW-1:0]    kind_q;
  logic [KeyW-1:0]     key_q;
  logic [ValueW-1:0]   value_q;
  logic [CntW-1:0]     count_q, count_d;

  logic                out_valid_q, out_valid_d;
  logic                ok_q;
  logic [ValueW-1:0]   mval_q;
  logic                last_q, full_q, empty_q;
  logic [CountOutW-1:0] cnt_q;

  cell_ctrl_t          ctrl;
  cell_chain_t         chain [SLOTS+1];
  cell_status_t        status [SLOTS];
  logic [ValueW-1:0]   cell_value [SLOTS];

  logic [SLOTS-1:0]    hit_vec, pend_vec, sel_vec;
  logic [ValueW-1:0]   sel_value;
  logic                any_key, any_pair, have_free, last_calc;
  logic                out_free, in_acc, load_out;
  logic                res_ok, res_last;
  logic [ValueW-1:0]   res_value;
  logic [CntW+CountOutW-1:0] cnt_ext;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Row of slot cells
  assign chain[0] = '0;
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    hbss_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .chain_i  (chain[g]),
      .chain_o  (chain[g+1]),
      .status_o (status[g]),
      .value_o  (cell_value[g])
    );
    assign hit_vec[g]  = status[g].key_hit;
    assign pend_vec[g] = status[g].pend;
    assign sel_vec[g]  = status[g].sel;
  end

  // Gather the selected value; at most one cell drives nonzero
  always_comb begin
    sel_value = '0;
    for (int i = 0; i < SLOTS; i++) begin
      sel_value = sel_value | cell_value[i];
    end
  end

  assign any_key   = |hit_vec;
  assign any_pair  = chain[SLOTS].pair;
  assign have_free = chain[SLOTS].free;
  assign last_calc = ~|(pend_vec & ~sel_vec);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (kind_q == KIND_LOOKUP && any_key) begin
          state_d = ST_EMIT;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free && last_calc) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_ready_o    = 1'b0;
    ctrl.key      = key_q;
    ctrl.value    = value_q;
    ctrl.ins_go   = 1'b0;
    ctrl.rem_go   = 1'b0;
    ctrl.set_pend = 1'b0;
    ctrl.pop      = 1'b0;
    load_out      = 1'b0;
    res_ok        = 1'b0;
    res_value     = '0;
    res_last      = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_EVAL: begin
        unique case (kind_q)
          KIND_INSERT: begin
            ctrl.ins_go = out_free && !any_pair && have_free;
            load_out    = out_free;
            res_ok      = !any_pair && have_free;
          end
          KIND_REMOVE: begin
            ctrl.rem_go = out_free && any_pair;
            load_out    = out_free;
            res_ok      = any_pair;
          end
          KIND_LOOKUP: begin
            ctrl.set_pend = any_key;
            load_out      = out_free && !any_key;
          end
          default: begin
            load_out = out_free;
          end
        endcase
      end
      ST_EMIT: begin
        ctrl.pop  = out_free;
        load_out  = out_free;
        res_ok    = 1'b1;
        res_value = sel_value;
        res_last  = last_calc;
      end
      default: ;
    endcase
  end

  // Track the number of valid slots
  always_comb begin
    count_d = count_q;
    if (ctrl.ins_go) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.rem_go) begin
      count_d = count_q - CntW'(1);
    end
  end

  assign cnt_ext = {{CountOutW{1'b0}}, count_d};

  // Result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q  <= kind_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      ok_q    <= res_ok;
      mval_q  <= res_value;
      last_q  <= res_last;
      full_q  <= (count_d == CntW'(SLOTS));
      empty_q <= (count_d == '0);
      cnt_q   <= cnt_ext[CountOutW-1:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = ok_q;
  assign matched_value_o = mval_q;
  assign last_o          = last_q;
  assign full_res_o      = full_q;
  assign empty_res_o     = empty_q;
  assign valid_count_o   = cnt_q;

endmodule

FILE: rtl/core/hbss_checker.sv
// Port-level checks for hash_bucket_slot_store, attached by bind.
// Depends on hbss_pkg.
module hbss_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [hbss_pkg::KindW-1:0]    kind_i,
  input logic [hbss_pkg::KeyW-1:0]     key_i,
  input logic [hbss_pkg::ValueW-1:0]   value_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          ok_o,
  input logic [hbss_pkg::ValueW-1:0]   matched_value_o,
  input logic                          last_o,
  input logic                          full_res_o,
  input logic                          empty_res_o,
  input logic [hbss_pkg::CountOutW-1:0] valid_count_o
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(matched_value_o) && $stable(last_o))
    else $error("result changed while stalled");

  // Follow a non-final lookup result with the next one at once
  a_burst_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o)
    else $error("gap inside a lookup burst");

  // Only lookup matches produce several results
  a_burst_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> ok_o && !in_ready_o)
    else $error("non-final result without a match");

  // Report zero value when nothing matched
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> matched_value_o == '0)
    else $error("failed result carries a value");

  // Never report full and empty together
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(full_res_o && empty_res_o))
    else $error("full and empty at once");

endmodule

bind hash_bucket_slot_store hbss_checker u_hbss_checker (.*);
